FILE: design/bdll_pkg.sv
// ----------------------------------------------------------------------------
// bdll_pkg: shared types and constants for the bounded doubly linked list
// Pool size, pointer widths, request/result payloads, operation and status
// codes, and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package bdll_pkg;

    localparam int CAPACITY  = 64;
    localparam int VALUE_W   = 32;
    localparam int ADDR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int PTR_W     = $clog2(CAPACITY + 1);
    localparam int ENTRY_W   = PTR_W;
    localparam logic [PTR_W-1:0] NIL = PTR_W'(CAPACITY);

    // free-slot search looks at one group of used bits per cycle
    localparam int GRP_W     = 8;
    localparam int LO_W      = $clog2(GRP_W);
    localparam int NUM_GRP   = (CAPACITY + GRP_W - 1) / GRP_W;
    localparam int GRP_IDX_W = (NUM_GRP > 1) ? $clog2(NUM_GRP) : 1;
    localparam int SLOT_W    = GRP_IDX_W + LO_W;

    typedef enum logic [1:0] {
        OP_APPEND  = 2'd0,
        OP_PREPEND = 2'd1,
        OP_DELETE  = 2'd2,
        OP_CLEAR   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    typedef struct packed {
        t_op                       op;
        logic signed [VALUE_W-1:0] value;
    } t_req;

    typedef struct packed {
        t_status              status;
        logic [ENTRY_W-1:0]   entries;
    } t_rsp;

    typedef struct packed {
        logic load;
        logic scan_clr;
        logic scan_step;
        logic take_slot;
        logic ins_node;
        logic ins_link;
        logic start_walk;
        logic walk_next;
        logic unlink;
        logic clear;
        logic at_head;
    } t_cmd;

    typedef struct packed {
        logic               free_found;
        logic               scan_last;
        logic               walk_end;
        logic               match;
        logic [ENTRY_W-1:0] count;
    } t_sts;

endpackage

FILE: design/bounded_doubly_linked_list_unit.sv
// ----------------------------------------------------------------------------
// bounded_doubly_linked_list_unit: doubly linked list over a fixed slot pool
// Append, prepend, delete-first-match and clear on signed 32-bit values,
// each answered by one result item with status and entry count.
// ----------------------------------------------------------------------------
// One request is handled at a time; a finished result sits in an output
// register, so the next request is taken while it waits. Append and prepend
// search the used map in groups of 8 bits for the lowest free slot; a full
// pool answers after the search. Delete walks the list from the head, one
// slot read per cycle from the value and pointer memories, and stops at the
// first match or at the end of the list.
// No clearing pass follows reset.
module bounded_doubly_linked_list_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  bdll_pkg::t_req i_in_item,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output bdll_pkg::t_rsp o_out_item
);

    bdll_pkg::t_cmd cmd;
    bdll_pkg::t_sts sts;

    bdll_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_op        (i_in_item.op),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    bdll_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_value (i_in_item.value),
        .o_sts   (sts)
    );

endmodule

FILE: design/bdll_datapath.sv
// ----------------------------------------------------------------------------
// bdll_datapath: slot memories, used map, head/tail/count and list walker
// Value, next and prev memories with registered reads; free-slot group scan;
// link and unlink writes driven by controller commands.
// ----------------------------------------------------------------------------
module bdll_datapath (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  bdll_pkg::t_cmd                        i_cmd,
    input  logic signed [bdll_pkg::VALUE_W-1:0]   i_value,
    output bdll_pkg::t_sts                        o_sts
);

    logic signed [bdll_pkg::VALUE_W-1:0] mem_value [bdll_pkg::CAPACITY];
    logic [bdll_pkg::PTR_W-1:0]          mem_next  [bdll_pkg::CAPACITY];
    logic [bdll_pkg::PTR_W-1:0]          mem_prev  [bdll_pkg::CAPACITY];

    logic [bdll_pkg::CAPACITY-1:0]       r_used;
    logic [bdll_pkg::PTR_W-1:0]          r_first;
    logic [bdll_pkg::PTR_W-1:0]          r_last;
    logic [bdll_pkg::ENTRY_W-1:0]        r_count;
    logic [bdll_pkg::GRP_IDX_W-1:0]      r_grp;
    logic [bdll_pkg::ADDR_W-1:0]         r_slot;
    logic [bdll_pkg::PTR_W-1:0]          r_cur;
    logic [bdll_pkg::PTR_W-1:0]          n_cur;
    logic [bdll_pkg::PTR_W-1:0]          r_steps;
    logic signed [bdll_pkg::VALUE_W-1:0] r_value;

    logic signed [bdll_pkg::VALUE_W-1:0] r_rd_value;
    logic [bdll_pkg::PTR_W-1:0]          r_rd_next;
    logic [bdll_pkg::PTR_W-1:0]          r_rd_prev;

    logic [bdll_pkg::NUM_GRP*bdll_pkg::GRP_W-1:0] used_pad;
    logic [bdll_pkg::GRP_W-1:0]          grp_bits;
    logic [bdll_pkg::LO_W-1:0]           lo;
    logic [bdll_pkg::SLOT_W-1:0]         slot_cand;
    logic [bdll_pkg::PTR_W-1:0]          slot_ptr;
    logic [bdll_pkg::ADDR_W-1:0]         rd_addr;

    logic                                nx_we;
    logic [bdll_pkg::ADDR_W-1:0]         nx_addr;
    logic [bdll_pkg::PTR_W-1:0]          nx_data;
    logic                                pv_we;
    logic [bdll_pkg::ADDR_W-1:0]         pv_addr;
    logic [bdll_pkg::PTR_W-1:0]          pv_data;

    // free-slot search over the current group, lowest index wins
    always_comb begin
        used_pad = '1;
        used_pad[bdll_pkg::CAPACITY-1:0] = r_used;
        grp_bits = used_pad[r_grp*bdll_pkg::GRP_W +: bdll_pkg::GRP_W];
        lo = '0;
        for (int i = bdll_pkg::GRP_W - 1; i >= 0; i--) begin
            if (!grp_bits[i]) begin
                lo = bdll_pkg::LO_W'(i);
            end
        end
    end

    assign slot_cand = {r_grp, lo};
    assign slot_ptr  = bdll_pkg::PTR_W'(r_slot);

    always_comb begin
        if (i_cmd.start_walk) begin
            n_cur = r_first;
        end else if (i_cmd.walk_next) begin
            n_cur = r_rd_next;
        end else begin
            n_cur = r_cur;
        end
    end

    assign rd_addr = n_cur[bdll_pkg::ADDR_W-1:0];

    // next-pointer write port
    always_comb begin
        nx_we   = 1'b0;
        nx_addr = r_slot;
        nx_data = bdll_pkg::NIL;
        if (i_cmd.unlink) begin
            nx_we   = (r_rd_prev != bdll_pkg::NIL);
            nx_addr = r_rd_prev[bdll_pkg::ADDR_W-1:0];
            nx_data = r_rd_next;
        end else if (i_cmd.ins_node) begin
            nx_we   = 1'b1;
            nx_addr = r_slot;
            nx_data = i_cmd.at_head ? r_first : bdll_pkg::NIL;
        end else if (i_cmd.ins_link) begin
            nx_we   = !i_cmd.at_head && (r_last != bdll_pkg::NIL);
            nx_addr = r_last[bdll_pkg::ADDR_W-1:0];
            nx_data = slot_ptr;
        end
    end

    // prev-pointer write port
    always_comb begin
        pv_we   = 1'b0;
        pv_addr = r_slot;
        pv_data = bdll_pkg::NIL;
        if (i_cmd.unlink) begin
            pv_we   = (r_rd_next != bdll_pkg::NIL);
            pv_addr = r_rd_next[bdll_pkg::ADDR_W-1:0];
            pv_data = r_rd_prev;
        end else if (i_cmd.ins_node) begin
            pv_we   = 1'b1;
            pv_addr = r_slot;
            pv_data = i_cmd.at_head ? bdll_pkg::NIL : r_last;
        end else if (i_cmd.ins_link) begin
            pv_we   = i_cmd.at_head && (r_first != bdll_pkg::NIL);
            pv_addr = r_first[bdll_pkg::ADDR_W-1:0];
            pv_data = slot_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_node) begin
            mem_value[r_slot] <= r_value;
        end
        if (nx_we) begin
            mem_next[nx_addr] <= nx_data;
        end
        if (pv_we) begin
            mem_prev[pv_addr] <= pv_data;
        end
        r_rd_value <= mem_value[rd_addr];
        r_rd_next  <= mem_next[rd_addr];
        r_rd_prev  <= mem_prev[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        if (i_cmd.load) begin
            r_value <= i_value;
        end
        if (i_cmd.take_slot) begin
            r_slot <= slot_cand[bdll_pkg::ADDR_W-1:0];
        end
        if (i_cmd.start_walk) begin
            r_steps <= '0;
        end else if (i_cmd.walk_next) begin
            r_steps <= r_steps + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_used  <= '0;
            r_first <= bdll_pkg::NIL;
            r_last  <= bdll_pkg::NIL;
            r_count <= '0;
            r_grp   <= '0;
        end else begin
            if (i_cmd.scan_clr) begin
                r_grp <= '0;
            end else if (i_cmd.scan_step) begin
                r_grp <= r_grp + 1'b1;
            end
            if (i_cmd.ins_node) begin
                r_used[r_slot] <= 1'b1;
            end
            if (i_cmd.ins_link) begin
                if (i_cmd.at_head) begin
                    if (r_first == bdll_pkg::NIL) begin
                        r_last <= slot_ptr;
                    end
                    r_first <= slot_ptr;
                end else begin
                    if (r_last == bdll_pkg::NIL) begin
                        r_first <= slot_ptr;
                    end
                    r_last <= slot_ptr;
                end
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.unlink) begin
                if (r_rd_prev == bdll_pkg::NIL) begin
                    r_first <= r_rd_next;
                end
                if (r_rd_next == bdll_pkg::NIL) begin
                    r_last <= r_rd_prev;
                end
                r_used[r_cur[bdll_pkg::ADDR_W-1:0]] <= 1'b0;
                if (r_count != '0) begin
                    r_count <= r_count - 1'b1;
                end
            end
        end
    end

    assign o_sts.free_found = !(&grp_bits);
    assign o_sts.scan_last  = (r_grp == bdll_pkg::GRP_IDX_W'(bdll_pkg::NUM_GRP - 1));
    assign o_sts.walk_end   = (r_cur == bdll_pkg::NIL)
                           || (r_steps == bdll_pkg::PTR_W'(bdll_pkg::CAPACITY));
    assign o_sts.match      = (r_rd_value == r_value);
    assign o_sts.count      = r_count;

endmodule

FILE: design/bdll_ctrl.sv
// ----------------------------------------------------------------------------
// bdll_ctrl: request sequencer and result register
// Accepts one request at a time, steps the datapath through scan, link,
// walk, unlink or clear, and holds the result item until it is taken.
// ----------------------------------------------------------------------------
module bdll_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  bdll_pkg::t_op      i_op,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output bdll_pkg::t_rsp     o_out_item,
    output bdll_pkg::t_cmd     o_cmd,
    input  bdll_pkg::t_sts     i_sts
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_INS_NODE,
        S_INS_LINK,
        S_WALK,
        S_UNLINK,
        S_CLEAR,
        S_RESP
    } t_state;

    t_state            r_state;
    logic              r_at_head;
    bdll_pkg::t_status r_status;
    logic              r_out_valid;
    bdll_pkg::t_rsp    r_out_item;
    logic              out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_comb begin
        o_cmd         = '0;
        o_cmd.at_head = r_at_head;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    case (i_op)
                        bdll_pkg::OP_APPEND,
                        bdll_pkg::OP_PREPEND: o_cmd.scan_clr   = 1'b1;
                        bdll_pkg::OP_DELETE:  o_cmd.start_walk = 1'b1;
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                if (i_sts.free_found) begin
                    o_cmd.take_slot = 1'b1;
                end else if (!i_sts.scan_last) begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_INS_NODE: o_cmd.ins_node = 1'b1;
            S_INS_LINK: o_cmd.ins_link = 1'b1;
            S_WALK: begin
                if (!i_sts.walk_end && !i_sts.match) begin
                    o_cmd.walk_next = 1'b1;
                end
            end
            S_UNLINK: o_cmd.unlink = 1'b1;
            S_CLEAR:  o_cmd.clear  = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_at_head   <= 1'b0;
            r_status    <= bdll_pkg::ST_DONE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_RESP && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_at_head <= (i_op == bdll_pkg::OP_PREPEND);
                        case (i_op)
                            bdll_pkg::OP_APPEND,
                            bdll_pkg::OP_PREPEND: r_state <= S_SCAN;
                            bdll_pkg::OP_DELETE:  r_state <= S_WALK;
                            default:              r_state <= S_CLEAR;
                        endcase
                    end
                end
                S_SCAN: begin
                    if (i_sts.free_found) begin
                        r_state <= S_INS_NODE;
                    end else if (i_sts.scan_last) begin
                        r_status <= bdll_pkg::ST_FULL;
                        r_state  <= S_RESP;
                    end
                end
                S_INS_NODE: r_state <= S_INS_LINK;
                S_INS_LINK: begin
                    r_status <= bdll_pkg::ST_DONE;
                    r_state  <= S_RESP;
                end
                S_WALK: begin
                    if (i_sts.walk_end) begin
                        r_status <= bdll_pkg::ST_NOT_FOUND;
                        r_state  <= S_RESP;
                    end else if (i_sts.match) begin
                        r_state <= S_UNLINK;
                    end
                end
                S_UNLINK, S_CLEAR: begin
                    r_status <= bdll_pkg::ST_DONE;
                    r_state  <= S_RESP;
                end
                S_RESP: begin
                    if (out_free) begin
                        r_out_item.status  <= r_status;
                        r_out_item.entries <= i_sts.count;
                        r_state            <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
